>>> hw/rtl/polyphonic_sine_voice_mixer_top_assert.svh
// assertion macros shared by the checker files of the voice mixer
// no dependencies; take it with an include of the bare file name
`ifndef POLYPHONIC_SINE_VOICE_MIXER_TOP_ASSERT_SVH
`define POLYPHONIC_SINE_VOICE_MIXER_TOP_ASSERT_SVH

// antecedent and consequent in the same cycle
`define PSVM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent in the cycle after the antecedent
`define PSVM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/psvm_pkg.sv
// shared types, constants and constant tables of the polyphonic voice mixer
// no dependencies; used by the cell, the mac unit and the top level
package psvm_pkg;

   localparam int NUM_VOICES_DEFAULT = 10;
   localparam int PHASE_BITS         = 32;
   localparam int SINE_TABLE_BITS    = 10;
   localparam int SAMPLE_RATE_HZ     = 44100;
   localparam int QUARTER_BITS       = SINE_TABLE_BITS - 2;
   localparam int QUARTER_SIZE       = 1 << QUARTER_BITS;
   localparam int NOTE_COUNT         = 128;
   localparam int SAMPLE_W           = 16;
   localparam int MAG_W              = SAMPLE_W - 1;
   localparam int PROD_W             = 33;

   localparam logic [7:0]  NOTE_ON     = 8'h90;
   localparam logic [7:0]  NOTE_OFF    = 8'h80;
   localparam logic        OP_TICK     = 1'b0;
   localparam logic        OP_MIDI     = 1'b1;
   localparam logic [15:0] GAIN_RESET  = 16'd6554;
   localparam logic [15:0] ROUND_HALF  = 16'h8000;

   typedef struct packed {
      logic       operation;
      logic [7:0] status_byte;
      logic [6:0] note_number;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mixed_sample;
   } rsp_type;

   typedef struct packed {
      logic [15:0] voice_gain;
   } csr_type;

   typedef struct packed {
      logic                  active;
      logic [PHASE_BITS-1:0] phase;
      logic [PHASE_BITS-1:0] step;
   } voice_type;

   typedef struct packed {
      logic shift;
      logic set_on;
      logic set_off;
   } cell_ctrl_type;

   typedef struct packed {
      logic                  valid;
      logic [PHASE_BITS-1:0] phase;
   } mac_in_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef logic [MAG_W-1:0]      sine_table_type [QUARTER_SIZE];
   typedef logic [PHASE_BITS-1:0] step_table_type [NOTE_COUNT];
   typedef logic [63:0]           octave_table_type [12];

   // notes 120..131 in Hz, unsigned Q16
   localparam octave_table_type TOP_OCTAVE_Q16 = '{
      64'd548668578, 64'd581294109, 64'd615859655, 64'd652480576,
      64'd691279090, 64'd732384684, 64'd775934544, 64'd822074013,
      64'd870957077, 64'd922746880, 64'd977616265, 64'd1035748353
   };

   // sin(pi/2 * x), x in Q30, result in Q15
   function automatic logic [MAG_W-1:0] quarter_sine(logic [63:0] x);
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      x2 = (x * x) >> 30;
      t  = 64'd172272;
      t  = 64'd5026995 - ((x2 * t) >> 30);
      t  = 64'd85569306 - ((x2 * t) >> 30);
      t  = 64'd693598668 - ((x2 * t) >> 30);
      t  = 64'd1686629713 - ((x2 * t) >> 30);
      s  = (((x * t) >> 30) + 64'd16384) >> 15;
      if (s > 64'd32767) begin
         s = 64'd32767;
      end
      return s[MAG_W-1:0];
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      for (int k = 0; k < QUARTER_SIZE; k++) begin
         tbl[k] = quarter_sine(64'(k) << (30 - QUARTER_BITS));
      end
      return tbl;
   endfunction

   function automatic step_table_type build_note_rom();
      step_table_type tbl;
      logic [63:0]    num;
      logic [63:0]    quo;
      int             e;
      for (int n = 0; n < NOTE_COUNT; n++) begin
         e = PHASE_BITS - 26 + n / 12;
         if (e >= 0) begin
            num = TOP_OCTAVE_Q16[n % 12] << e;
         end else begin
            num = TOP_OCTAVE_Q16[n % 12] >> (-e);
         end
         quo    = num / SAMPLE_RATE_HZ;
         tbl[n] = quo[PHASE_BITS-1:0];
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();
   localparam logic [MAG_W-1:0] SINE_PEAK =
      quarter_sine(64'(QUARTER_SIZE) << (30 - QUARTER_BITS));
   localparam step_table_type NOTE_STEP  = build_note_rom();

endpackage

>>> hw/rtl/psvm_chan_if.sv
// valid/ready channel with a typed payload, used for request, response and csr
// no dependencies; the payload type comes in as a parameter
interface psvm_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/psvm_cell.sv
// one voice slot of the rotating voice ring
// depends on psvm_pkg for the voice record and cell control
module psvm_cell import psvm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctrl_type         ctrl,
   input  logic [PHASE_BITS-1:0] step_new,
   input  voice_type             from_next,
   output voice_type             q
);

   logic                  active_ff, active_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in;
   logic [PHASE_BITS-1:0] step_ff, step_in;

   always_comb begin
      active_in = active_ff;
      phase_in  = phase_ff;
      step_in   = step_ff;
      if (ctrl.shift) begin
         active_in = from_next.active;
         phase_in  = from_next.phase;
         step_in   = from_next.step;
      end else if (ctrl.set_on) begin
         // phase keeps running from where it was
         active_in = 1'b1;
         step_in   = step_new;
      end else if (ctrl.set_off) begin
         active_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         phase_ff  <= '0;
      end else begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
   end

   assign q.active = active_ff;
   assign q.phase  = phase_ff;
   assign q.step   = step_ff;

endmodule

>>> hw/rtl/psvm_mac.sv
// shared sine lookup, gain multiply and mix accumulator
// depends on psvm_pkg for the sine table and widths
module psvm_mac import psvm_pkg::*; #(
   parameter int ACC_W = 37
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    clear,
   input  mac_in_type              mac_in,
   input  logic [15:0]             gain,
   output logic signed [ACC_W-1:0] acc,
   output logic                    busy
);

   logic [SINE_TABLE_BITS-1:0] idx;
   logic [1:0]                 quad;
   logic [QUARTER_BITS-1:0]    j;
   logic [QUARTER_BITS:0]      pos;
   logic [MAG_W-1:0]           mag;

   logic                       v1_ff, v2_ff;
   logic signed [SAMPLE_W-1:0] sine_ff, sine_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;

   // index is the top bits of twice the phase
   assign idx  = mac_in.phase[PHASE_BITS-2 -: SINE_TABLE_BITS];
   assign quad = idx[SINE_TABLE_BITS-1 -: 2];
   assign j    = idx[QUARTER_BITS-1:0];

   always_comb begin
      pos = quad[0] ? ((QUARTER_BITS+1)'(QUARTER_SIZE) - {1'b0, j}) : {1'b0, j};
      if (pos[QUARTER_BITS]) begin
         mag = SINE_PEAK;
      end else begin
         mag = SINE_TABLE[pos[QUARTER_BITS-1:0]];
      end
      sine_in = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   end

   assign prod_in = $signed({1'b0, gain}) * sine_ff;

   always_comb begin
      acc_in = acc_ff;
      if (clear) begin
         acc_in = '0;
      end else if (v2_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         acc_ff <= '0;
      end else begin
         v1_ff  <= mac_in.valid;
         v2_ff  <= v1_ff;
         acc_ff <= acc_in;
      end
   end

   always_ff @(posedge clock) begin
      sine_ff <= sine_in;
      prod_ff <= prod_in;
   end

   assign acc  = acc_ff;
   assign busy = v1_ff | v2_ff;

endmodule

>>> hw/rtl/polyphonic_sine_voice_mixer_top.sv
// Polyphonic sine voice mixer. A MIDI request (note on / note off) is taken in the idle
// state and gives no response. A sample tick rotates the ring of NUM_VOICES voice
// cells once through the shared sine lookup, gain multiplier and accumulator, one
// voice per cycle, then rounds and saturates the mix. The response is registered after
// the drain, once the response register is free or being read. The drain after the
// rotation waits only for the voices that are in use, so the response comes earlier
// when the top voice slots are free. The next request is taken in the cycle after the
// response is registered. A finished sample waits in the response register while
// further requests are taken.
// depends on psvm_pkg, psvm_chan_if, psvm_cell and psvm_mac
module polyphonic_sine_voice_mixer_top import psvm_pkg::*; #(
   parameter int NUM_VOICES = NUM_VOICES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   psvm_chan_if.sink   req_chan,
   psvm_chan_if.source rsp_chan,
   psvm_chan_if.sink   csr_chan
);

   localparam int CW    = $clog2(NUM_VOICES + 1);
   localparam int VW    = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
   localparam int ACC_W = PROD_W + $clog2(NUM_VOICES + 1);
   localparam int QW    = ACC_W + 1 - 16;

   state_type             state_ff, state_in;
   logic [VW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         in_use_ff, in_use_in;
   logic [15:0]           gain_ff, gain_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0]   rsp_sample_ff, rsp_sample_in;

   logic                  req_fire, tick_fire, note_on_ok, note_off_ok;
   logic                  shift_en, mac_clear, rsp_load, req_ready;
   logic                  mac_busy;
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W:0]   rnd;
   logic signed [QW-1:0]    q;
   mac_in_type            mac_in;
   voice_type             wrap;
   logic [PHASE_BITS-1:0] step_new;

   voice_type             cell_q [NUM_VOICES];
   voice_type             cell_d [NUM_VOICES];
   cell_ctrl_type         ctrl   [NUM_VOICES];

   req_type req;
   assign req = req_chan.data;

   assign req_fire    = req_chan.valid & req_ready;
   assign tick_fire   = req_fire & (req.operation == OP_TICK);
   assign note_on_ok  = req_fire & (req.operation == OP_MIDI) & (req.status_byte == NOTE_ON)
                        & (in_use_ff != CW'(NUM_VOICES));
   assign note_off_ok = req_fire & (req.operation == OP_MIDI) & (req.status_byte == NOTE_OFF)
                        & (in_use_ff != '0);
   assign step_new    = NOTE_STEP[req.note_number];

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (tick_fire) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == VW'(NUM_VOICES - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!mac_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      shift_en  = 1'b0;
      mac_clear = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            mac_clear = tick_fire;
         end
         ST_ISSUE: begin
            shift_en = 1'b1;
         end
         ST_DRAIN: begin
            shift_en = 1'b0;
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || rsp_chan.ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      in_use_in = in_use_ff;
      if (note_on_ok) begin
         in_use_in = in_use_ff + 1'b1;
      end else if (note_off_ok) begin
         in_use_in = in_use_ff - 1'b1;
      end
   end

   assign gain_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.data.voice_gain : gain_ff;

   // head voice advances as it wraps to the tail
   assign wrap.active = cell_q[0].active;
   assign wrap.step   = cell_q[0].step;
   assign wrap.phase  = cell_q[0].phase + (cell_q[0].active ? cell_q[0].step : '0);

   assign mac_in.valid = shift_en & cell_q[0].active;
   assign mac_in.phase = cell_q[0].phase;

   for (genvar i = 0; i < NUM_VOICES; i++) begin : g_ring
      if (i == NUM_VOICES - 1) begin : g_tail
         assign cell_d[i] = wrap;
      end else begin : g_mid
         assign cell_d[i] = cell_q[i+1];
      end
      assign ctrl[i].shift   = shift_en;
      assign ctrl[i].set_on  = note_on_ok & (in_use_ff == CW'(i));
      assign ctrl[i].set_off = note_off_ok & (in_use_ff == CW'(i + 1));

      psvm_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl[i]),
         .step_new  (step_new),
         .from_next (cell_d[i]),
         .q         (cell_q[i])
      );
   end

   psvm_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .clear  (mac_clear),
      .mac_in (mac_in),
      .gain   (gain_ff),
      .acc    (acc),
      .busy   (mac_busy)
   );

   // round half up to q1.15, then saturate
   assign rnd = $signed({acc[ACC_W-1], acc}) + $signed({{(ACC_W-15){1'b0}}, ROUND_HALF});
   assign q   = rnd[ACC_W:16];

   always_comb begin
      if (q[QW-1:SAMPLE_W-1] == '0 || q[QW-1:SAMPLE_W-1] == '1) begin
         rsp_sample_in = q[SAMPLE_W-1:0];
      end else if (q[QW-1]) begin
         rsp_sample_in = {1'b1, {(SAMPLE_W-1){1'b0}}};
      end else begin
         rsp_sample_in = {1'b0, {(SAMPLE_W-1){1'b1}}};
      end
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         in_use_ff    <= '0;
         gain_ff      <= GAIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         in_use_ff    <= in_use_in;
         gain_ff      <= gain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_sample_ff <= rsp_sample_in;
      end
   end

   assign req_chan.ready         = req_ready;
   assign csr_chan.ready         = 1'b1;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.data.mixed_sample = rsp_sample_ff;

endmodule

>>> hw/rtl/psvm_checker.sv
// port-level checks on the voice mixer top, attached by bind
// depends on psvm_pkg and the assertion macro header
`include "polyphonic_sine_voice_mixer_top_assert.svh"

module psvm_checker import psvm_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                req_operation,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic [SAMPLE_W-1:0] rsp_sample
);

   // a tick keeps the block busy for the next cycle
   `PSVM_ASSERT_NEXT(a_tick_busy, clock, reset, req_valid && req_ready && req_operation == OP_TICK, !req_ready, "tick transaction did not block the request side")
   // midi messages finish at once
   `PSVM_ASSERT_NEXT(a_midi_fast, clock, reset, req_valid && req_ready && req_operation == OP_MIDI, req_ready, "midi transaction left the block busy")
   // a new sample only comes out of the busy phase
   `PSVM_ASSERT_NOW(a_rsp_from_busy, clock, reset, $rose(rsp_valid), $past(!req_ready), "response appeared while idle")
   `PSVM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_sample), "stalled response changed")

endmodule

bind polyphonic_sine_voice_mixer_top psvm_checker u_psvm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_operation (req_chan.data.operation),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_sample    (rsp_chan.data.mixed_sample)
);

>>> test/polyphonic_sine_voice_mixer_top_tb.sv
// self-checking testbench for the polyphonic sine voice mixer top level
// predicts every mixed sample from its own voice table and compares on the response channel
// depends on psvm_pkg, psvm_chan_if and polyphonic_sine_voice_mixer_top
module polyphonic_sine_voice_mixer_top_tb;
   import psvm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int VOICES         = NUM_VOICES_DEFAULT;
   localparam int DRAIN_CYCLES   = 24;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 400;

   // notes 120..131, Hz in unsigned Q16
   localparam logic [63:0] C9_OCTAVE_Q16 [12] = '{
      64'd548668578, 64'd581294109, 64'd615859655, 64'd652480576,
      64'd691279090, 64'd732384684, 64'd775934544, 64'd822074013,
      64'd870957077, 64'd922746880, 64'd977616265, 64'd1035748353
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   psvm_chan_if #(.payload_type(req_type)) req_if ();
   psvm_chan_if #(.payload_type(rsp_type)) rsp_if ();
   psvm_chan_if #(.payload_type(csr_type)) csr_if ();

   polyphonic_sine_voice_mixer_top u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // voice table as the block should hold it
   logic [PHASE_BITS-1:0] osc_phase [VOICES];
   logic [PHASE_BITS-1:0] osc_step  [VOICES];
   logic                  osc_on    [VOICES];
   int                    osc_count;
   logic [15:0]           gain_reg;

   logic signed [SAMPLE_W-1:0] pending_mix [$];

   int fail_count   = 0;
   int req_gap_pct  = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_req = 0;
   int quiet_cycles = 0;

   function automatic logic [PHASE_BITS-1:0] note_step(input logic [6:0] note);
      logic [63:0] f;
      logic [63:0] num;
      int          e;
      f = C9_OCTAVE_Q16[note % 12];
      e = PHASE_BITS - 26 + note / 12;
      if (e >= 0) begin
         num = f << e;
      end else begin
         num = f >> (-e);
      end
      num = num / 64'(SAMPLE_RATE_HZ);
      return num[PHASE_BITS-1:0];
   endfunction

   // sine of twice the phase, odd polynomial on the quarter wave
   function automatic logic signed [SAMPLE_W-1:0] wave_at(input logic [PHASE_BITS-1:0] ph);
      logic [SINE_TABLE_BITS-1:0] idx;
      logic [QUARTER_BITS:0]      pos;
      logic [63:0]                x;
      logic [63:0]                x2;
      logic [63:0]                acc;
      logic [63:0]                mag;
      logic signed [SAMPLE_W-1:0] v;
      idx = SINE_TABLE_BITS'(ph >> (PHASE_BITS - SINE_TABLE_BITS - 1));
      pos = {1'b0, idx[QUARTER_BITS-1:0]};
      if (idx[QUARTER_BITS]) begin
         pos = (QUARTER_BITS+1)'(QUARTER_SIZE) - pos;
      end
      x   = 64'(pos) << (30 - QUARTER_BITS);
      x2  = (x * x) >> 30;
      acc = 64'd5026995 - ((x2 * 64'd172272) >> 30);
      acc = 64'd85569306 - ((x2 * acc) >> 30);
      acc = 64'd693598668 - ((x2 * acc) >> 30);
      acc = 64'd1686629713 - ((x2 * acc) >> 30);
      mag = (((x * acc) >> 30) + 64'd16384) >> 15;
      if (mag > 64'd32767) begin
         mag = 64'd32767;
      end
      v = $signed({1'b0, mag[MAG_W-1:0]});
      if (idx[SINE_TABLE_BITS-1]) begin
         v = -v;
      end
      return v;
   endfunction

   // update the voice table for one accepted request, queue the sample a tick makes
   function automatic void predict_request(input req_type item);
      longint acc;
      longint g;
      longint s;
      longint q;
      if (item.operation == OP_TICK) begin
         acc = 0;
         g   = gain_reg;
         for (int v = 0; v < VOICES; v++) begin
            if (osc_on[v]) begin
               s   = wave_at(osc_phase[v]);
               acc = acc + g * s;
               osc_phase[v] = osc_phase[v] + osc_step[v];
            end
         end
         if (acc >= 0) begin
            q = (acc + 32768) >>> 16;
         end else begin
            q = -((-acc + 32767) >>> 16);
         end
         if (q > 32767) begin
            q = 32767;
         end
         if (q < -32768) begin
            q = -32768;
         end
         pending_mix.push_back(SAMPLE_W'(q));
      end else if (item.status_byte == NOTE_ON) begin
         if (osc_count < VOICES) begin
            osc_step[osc_count] = note_step(item.note_number);
            osc_on[osc_count]   = 1'b1;
            osc_count++;
         end
      end else if (item.status_byte == NOTE_OFF) begin
         if (osc_count > 0) begin
            osc_count--;
            osc_on[osc_count] = 1'b0;
         end
      end
   endfunction

   function automatic req_type make_req(input logic op, input logic [7:0] st,
                                        input logic [6:0] note);
      req_type it;
      it.operation   = op;
      it.status_byte = st;
      it.note_number = note;
      return it;
   endfunction

   // well-formed traffic most of the time, a little noise on the status byte
   function automatic req_type pick_req(input bit filling);
      req_type it;
      int      r;
      it = make_req(OP_MIDI, NOTE_ON, 7'($urandom));
      r  = $urandom_range(0, 99);
      if (r < 46) begin
         it.operation   = OP_TICK;
         it.status_byte = 8'($urandom);
      end else if (r < (filling ? 76 : 58)) begin
         it.status_byte = NOTE_ON;
      end else if (r < 92) begin
         it.status_byte = NOTE_OFF;
      end else if (r < 96) begin
         it.status_byte = 8'($urandom);
      end else begin
         // same messages on another channel
         it.status_byte = {($urandom_range(0, 1) != 0) ? NOTE_ON[7:4] : NOTE_OFF[7:4],
                           4'($urandom_range(1, 15))};
      end
      return it;
   endfunction

   task automatic send_req(input req_type item);
      if (req_gap_pct > 0 && $urandom_range(1, 100) <= req_gap_pct) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= item;
      do @(posedge clock); while (!req_if.ready);
      predict_request(item);
   endtask

   // let every predicted sample arrive, then give the block time to finish a midi transaction
   task automatic wait_quiet(input int settle);
      req_if.valid <= 1'b0;
      while (pending_mix.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_gain(input logic [15:0] g);
      csr_type c;
      wait_quiet(DRAIN_CYCLES);
      c.voice_gain = g;
      csr_if.valid <= 1'b1;
      csr_if.data  <= c;
      do @(posedge clock); while (!csr_if.ready);
      gain_reg = g;
      csr_if.valid <= 1'b0;
   endtask

   task automatic pick_idling(input bit allowed);
      int choice [3] = '{0, 10, 35};
      req_gap_pct   = allowed ? choice[$urandom_range(0, 2)] : 0;
      rsp_stall_pct = allowed ? choice[$urandom_range(0, 2)] : 0;
   endtask

   task automatic run_traffic(input int count, input bit idling);
      bit filling;
      filling = 1'b1;
      for (int i = 0; i < count; i++) begin
         if (i % 40 == 0) begin
            filling = ($urandom_range(0, 1) != 0);
            pick_idling(idling);
         end
         send_req(pick_req(filling));
      end
   endtask

   task automatic test_reset_state();
      send_req(make_req(OP_TICK, 8'h00, 7'h00));
      send_req(make_req(OP_MIDI, NOTE_OFF, 7'h00));
      send_req(make_req(OP_TICK, 8'h00, 7'h00));
   endtask

   task automatic test_midi_cases();
      send_req(make_req(OP_MIDI, NOTE_ON, 7'd0));
      send_req(make_req(OP_MIDI, NOTE_ON, 7'd127));
      send_req(make_req(OP_TICK, 8'hFF, 7'h7F));
      send_req(make_req(OP_MIDI, 8'h00, 7'd0));
      send_req(make_req(OP_MIDI, 8'hFF, 7'd127));
      send_req(make_req(OP_MIDI, 8'h91, 7'd127));
      send_req(make_req(OP_MIDI, 8'h81, 7'd127));
      // note off takes the newest voice whatever the note number says
      send_req(make_req(OP_MIDI, NOTE_OFF, 7'd5));
      send_req(make_req(OP_TICK, 8'h90, 7'h2A));
   endtask

   task automatic test_voice_limit_saturation();
      write_gain(16'hFFFF);
      while (osc_count < VOICES) begin
         send_req(make_req(OP_MIDI, NOTE_ON, 7'd127));
      end
      send_req(make_req(OP_MIDI, NOTE_ON, 7'd0));
      repeat (4) send_req(make_req(OP_TICK, 8'h00, 7'h00));
   endtask

   task automatic test_random_gain(input logic [15:0] g, input int count);
      write_gain(g);
      run_traffic(count, 1'b1);
   endtask

   task automatic test_rsp_backpressure();
      pick_idling(1'b0);
      rsp_hold_req = LONG_HOLD;
      while (rsp_hold_req != 0) @(posedge clock);
      for (int i = 0; i < 40; i++) begin
         send_req(pick_req(i < 20));
      end
   endtask

   task automatic test_sender_drain_pause();
      run_traffic(30, 1'b1);
      wait_quiet(1);
      run_traffic(30, 1'b1);
   endtask

   // result ready: random stall bursts, one long hold when asked
   initial begin : rsp_ready_gen
      int  hold;
      logic rdy;
      forever begin
         if (rsp_hold_req > 0) begin
            hold = rsp_hold_req;
            rsp_hold_req = 0;
            rdy  = 1'b0;
         end else if (rsp_stall_pct > 0 && $urandom_range(1, 100) <= rsp_stall_pct) begin
            hold = $urandom_range(1, 10);
            rdy  = 1'b0;
         end else begin
            hold = $urandom_range(1, 8);
            rdy  = 1'b1;
         end
         rsp_if.ready <= rdy;
         repeat (hold) @(posedge clock);
      end
   end

   always @(posedge clock) begin : mix_check
      logic signed [SAMPLE_W-1:0] want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_mix.size() == 0) begin
            if (fail_count < 10) begin
               $display("unexpected sample %0d with none predicted",
                        rsp_if.data.mixed_sample);
            end
            fail_count++;
         end else begin
            want = pending_mix.pop_front();
            if (rsp_if.data.mixed_sample !== want) begin
               if (fail_count < 10) begin
                  $display("mismatch: mixed_sample expected %0d got %0d",
                           want, rsp_if.data.mixed_sample);
               end
               fail_count++;
            end
         end
      end
   end

   // stops a hung run: too many cycles without any transaction
   always @(posedge clock) begin : watchdog
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : main_seq
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
      csr_if.valid <= 1'b0;
      csr_if.data  <= '0;
      for (int v = 0; v < VOICES; v++) begin
         osc_phase[v] = '0;
         osc_step[v]  = '0;
         osc_on[v]    = 1'b0;
      end
      osc_count = 0;
      gain_reg  = GAIN_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_state();
      test_midi_cases();
      test_voice_limit_saturation();
      test_random_gain(16'hFFFF, 220);
      test_random_gain(16'h0000, 120);
      test_random_gain(16'h0001, 150);
      test_rsp_backpressure();
      test_sender_drain_pause();
      test_random_gain(GAIN_RESET, 200);
      test_random_gain(16'($urandom), 220);
      // last stretch runs at full rate on both sides
      write_gain(16'($urandom));
      run_traffic(160, 1'b0);

      wait_quiet(DRAIN_CYCLES + 8);
      if (fail_count == 0 && pending_mix.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/psvm_pkg.sv
hw/rtl/psvm_chan_if.sv
hw/rtl/psvm_cell.sv
hw/rtl/psvm_mac.sv
hw/rtl/polyphonic_sine_voice_mixer_top.sv
hw/rtl/psvm_checker.sv
test/polyphonic_sine_voice_mixer_top_tb.sv
